### src/tusa_pkg.sv
package tusa_pkg;

	localparam int UNITS_DEF   = 16;
	localparam int TEX_IDS_DEF = 256;
	localparam int CFG_W       = 5;
	localparam int TAG_W       = 8;
	localparam int UNIT_W      = 4;
	localparam int STATUS_W    = 3;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic FUNC_REG  = 1'b0;
	localparam logic FUNC_BIND = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NEWREG  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OLDREG  = 3'd5;

	typedef struct packed {
		logic             func;
		logic [TAG_W-1:0] tex_id;
	} req_t;

	typedef struct packed {
		logic [UNIT_W-1:0]   unit;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic take;
		logic look;
		logic scan;
		logic put;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_scan;
		logic scan_done;
		logic out_free;
	} sts_t;

	function automatic int active_last(input logic [CFG_W-1:0] v, input int units);
		int n;
		n = int'(v);
		if (n < 1) n = 1;
		if (n > units) n = units;
		return n - 1;
	endfunction

endpackage

### src/tusa_ram.sv
module tusa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/tusa_ctrl.sv
module tusa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tusa_pkg::sts_t sts,
	output tusa_pkg::cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.need_scan ? S_SCAN : S_PUT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE)
		else $error("item taken outside idle");

	a_put_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> state_q == S_IDLE)
		else $error("put did not return to idle");

	a_scan_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.scan) |-> $past(cmd.look) && $past(sts.need_scan))
		else $error("scan started without a bind lookup");

	a_stall_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> req_stall)
		else $error("input open during clearing pass");

endmodule

### src/tusa_dp.sv
module tusa_dp #(
	parameter int UNITS   = tusa_pkg::UNITS_DEF,
	parameter int TEX_IDS = tusa_pkg::TEX_IDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tusa_pkg::req_t             req,
	input  logic                       cfg_we,
	input  logic [tusa_pkg::CFG_W-1:0] cfg_data,
	input  tusa_pkg::cmd_t             cmd,
	output tusa_pkg::sts_t             sts,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tusa_pkg::rsp_t             rsp
);

	localparam int UW         = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int FLAG_DEPTH = (TEX_IDS < 256) ? TEX_IDS : 256;
	localparam int FW         = $clog2(FLAG_DEPTH);

	logic [UNITS-1:0]          valid_q;
	logic [UW-1:0]             last_q;
	logic [FW-1:0]             clr_ptr_q;
	logic [tusa_pkg::TAG_W-1:0] id_q;
	logic                      func_q;
	tusa_pkg::rsp_t            res_q;
	tusa_pkg::rsp_t            rsp_q;
	logic                      rsp_valid_q;
	logic [UW-1:0]             rd_ptr_q;
	logic                      rd_act_q;
	logic [UW-1:0]             cmp_ptr_s1;
	logic                      cmp_vld_s1;
	logic                      emp_q;
	logic [UW-1:0]             emp_at_q;

	logic                       in_range;
	logic                       flag_rd;
	logic                       flag_hit;
	logic                       flag_we;
	logic [FW-1:0]              flag_waddr;
	logic                       flag_wdata;
	logic                       issue;
	logic [tusa_pkg::TAG_W-1:0] tag_rd;
	logic                       slot_vld;
	logic                       hit;
	logic                       emp_now;
	logic                       have_emp;
	logic [UW-1:0]              emp_at;
	logic [UW-1:0]              wr_ptr;
	logic                       scan_done;
	logic                       commit;
	tusa_pkg::rsp_t             look_res;
	tusa_pkg::rsp_t             bind_res;

	assign in_range = int'(id_q) < TEX_IDS;
	assign flag_hit = in_range && flag_rd;
	assign issue    = cmd.scan && rd_act_q;

	assign flag_we    = cmd.clear || (cmd.look && func_q == tusa_pkg::FUNC_REG && in_range);
	assign flag_waddr = cmd.clear ? clr_ptr_q : id_q[FW-1:0];
	assign flag_wdata = !cmd.clear;

	tusa_ram #(
		.W     (1),
		.DEPTH (FLAG_DEPTH),
		.AW    (FW)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (req.tex_id[FW-1:0]),
		.rdata (flag_rd)
	);

	tusa_ram #(
		.W     (tusa_pkg::TAG_W),
		.DEPTH (UNITS),
		.AW    (UW)
	) u_tag_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (wr_ptr),
		.wdata (id_q),
		.raddr (rd_ptr_q),
		.rdata (tag_rd)
	);

	assign slot_vld  = valid_q[cmp_ptr_s1];
	assign hit       = cmp_vld_s1 && slot_vld && (tag_rd == id_q);
	assign emp_now   = cmp_vld_s1 && !slot_vld;
	assign have_emp  = emp_now || emp_q;
	assign emp_at    = emp_now ? cmp_ptr_s1 : emp_at_q;
	assign wr_ptr    = have_emp ? emp_at : '0;
	assign scan_done = cmp_vld_s1 && (hit || (cmp_ptr_s1 == last_q));
	assign commit    = cmd.scan && scan_done && !hit;

	always_comb begin
		look_res.unit = '0;
		if (!in_range || func_q == tusa_pkg::FUNC_BIND) begin
			look_res.status = tusa_pkg::ST_UNKNOWN;
		end else if (flag_hit) begin
			look_res.status = tusa_pkg::ST_OLDREG;
		end else begin
			look_res.status = tusa_pkg::ST_NEWREG;
		end
	end

	always_comb begin
		if (hit) begin
			bind_res.unit   = tusa_pkg::UNIT_W'(cmp_ptr_s1);
			bind_res.status = tusa_pkg::ST_HIT;
		end else if (have_emp) begin
			bind_res.unit   = tusa_pkg::UNIT_W'(emp_at);
			bind_res.status = tusa_pkg::ST_FREE;
		end else begin
			bind_res.unit   = '0;
			bind_res.status = tusa_pkg::ST_EVICT;
		end
	end

	assign sts.clear_done = clr_ptr_q == FW'(FLAG_DEPTH - 1);
	assign sts.need_scan  = (func_q == tusa_pkg::FUNC_BIND) && flag_hit;
	assign sts.scan_done  = scan_done;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			last_q      <= UW'(tusa_pkg::active_last(tusa_pkg::CFG_RESET, UNITS));
			clr_ptr_q   <= '0;
			rd_act_q    <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			emp_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				last_q <= UW'(tusa_pkg::active_last(cfg_data, UNITS));
			end
			if (cmd.clear) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (commit) begin
				valid_q[wr_ptr] <= 1'b1;
			end
			if (cmd.take) begin
				rd_act_q <= 1'b1;
			end else if (issue && rd_ptr_q == last_q) begin
				rd_act_q <= 1'b0;
			end
			cmp_vld_s1 <= issue;
			if (cmd.take) begin
				emp_q <= 1'b0;
			end else if (cmd.scan && emp_now) begin
				emp_q <= 1'b1;
			end
			if (cmd.put) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			id_q     <= req.tex_id;
			func_q   <= req.func;
			rd_ptr_q <= '0;
		end else if (issue) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		if (cmd.look) begin
			res_q <= look_res;
		end else if (cmd.scan && scan_done) begin
			res_q <= bind_res;
		end
		cmp_ptr_s1 <= rd_ptr_q;
		if (cmd.scan && emp_now) begin
			emp_at_q <= cmp_ptr_s1;
		end
		if (cmd.put) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_look_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> cmd.look)
		else $error("lookup did not follow take");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> cmp_ptr_s1 <= last_q)
		else $error("scan ran past the active units");

	a_commit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_q[$past(wr_ptr)])
		else $error("claimed unit not marked valid");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.status <= tusa_pkg::ST_OLDREG)
		else $error("bad status code");

endmodule

### src/texture_unit_slot_allocator_unit.sv
// channel | valid     | stall     | word            | fields
// req     | req_valid | req_stall | req  (req_t)    | func, tex_id
// rsp     | rsp_valid | rsp_stall | rsp  (rsp_t)    | unit, status
// cfg     | cfg_we    | -         | cfg_data [4:0]  | units_in_use
//
// Register and unknown words: a flag lookup, then the result word goes to the output register.
// Bind words of a registered identifier: lookup, then one active unit per cycle through the
// tag RAM read port until a hit or the last active unit, then the result word.
// Next word is taken once the previous result has entered the output register.
// arst_n clears all unit valid bits, sets 16 units and starts a clearing pass over every
// flag RAM entry with req_stall held high.
// A result word waits in the output register under rsp_stall.
module texture_unit_slot_allocator_unit #(
	parameter int UNITS   = tusa_pkg::UNITS_DEF,
	parameter int TEX_IDS = tusa_pkg::TEX_IDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  tusa_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tusa_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [tusa_pkg::CFG_W-1:0] cfg_data
);

	tusa_pkg::cmd_t cmd;
	tusa_pkg::sts_t sts;

	tusa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tusa_dp #(
		.UNITS   (UNITS),
		.TEX_IDS (TEX_IDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
